// ===== rtl/photon_cluster_classifier_defines.svh =====
// Assertion helpers used by photon_cluster_classifier.sv.
`ifndef PHOTON_CLUSTER_CLASSIFIER_DEFINES_SVH
`define PHOTON_CLUSTER_CLASSIFIER_DEFINES_SVH

// Implication checked every clock, held off during reset.
`define PCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent in the next cycle.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcc_pkg.sv =====
package pcc_pkg;

  localparam int unsigned RMS_W   = 20;
  localparam int unsigned SIGMA_W = 4;
  localparam int unsigned THR_W   = RMS_W + SIGMA_W;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 4'd3;

  // APB side
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_SIGMA = 1'b0;

  typedef enum logic [1:0] {
    CLASS_PEDESTAL = 2'd0,
    CLASS_PHOTON   = 2'd1,
    CLASS_PEAK     = 2'd2,
    CLASS_NEG      = 2'd3
  } pcc_class_e;

endpackage

// ===== rtl/pcc_window.sv =====
module pcc_window import pcc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 17
) (
  input  logic signed [VALUE_WIDTH-1:0]   pix_i [9],
  output logic signed [VALUE_WIDTH+3:0]   tot_o,
  output logic signed [VALUE_WIDTH+1:0]   best_o,
  output logic signed [VALUE_WIDTH-1:0]   max_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned QW = W + 2;
  localparam int unsigned TW = W + 4;

  function automatic logic signed [W-1:0] vmax(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [QW-1:0] qmax(logic signed [QW-1:0] a,
                                                logic signed [QW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic signed [W-1:0]  m0, m1, m2, m3, m4, n0, n1, o0;
  logic signed [QW-1:0] q_nw, q_ne, q_sw, q_se;

  // window total, balanced adds
  assign tot_o = (TW'(pix_i[0]) + TW'(pix_i[1]) + TW'(pix_i[2]))
               + (TW'(pix_i[3]) + TW'(pix_i[4]) + TW'(pix_i[5]))
               + (TW'(pix_i[6]) + TW'(pix_i[7]) + TW'(pix_i[8]));

  // corner quadrants that hold the centre
  assign q_nw = QW'(pix_i[0]) + QW'(pix_i[1]) + QW'(pix_i[3]) + QW'(pix_i[4]);
  assign q_ne = QW'(pix_i[1]) + QW'(pix_i[2]) + QW'(pix_i[4]) + QW'(pix_i[5]);
  assign q_sw = QW'(pix_i[3]) + QW'(pix_i[4]) + QW'(pix_i[6]) + QW'(pix_i[7]);
  assign q_se = QW'(pix_i[4]) + QW'(pix_i[5]) + QW'(pix_i[7]) + QW'(pix_i[8]);

  assign best_o = qmax(qmax(q_nw, q_ne), qmax(q_sw, q_se));

  // max tree, floor at zero
  assign m0    = vmax(pix_i[0], pix_i[1]);
  assign m1    = vmax(pix_i[2], pix_i[3]);
  assign m2    = vmax(pix_i[4], pix_i[5]);
  assign m3    = vmax(pix_i[6], pix_i[7]);
  assign m4    = vmax(pix_i[8], '0);
  assign n0    = vmax(m0, m1);
  assign n1    = vmax(m2, m3);
  assign o0    = vmax(n0, n1);
  assign max_o = vmax(o0, m4);

endmodule

// ===== rtl/pcc_classify.sv =====
module pcc_classify import pcc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH   = 17,
  parameter int unsigned RMS_FRAC_BITS = 4
) (
  input  logic signed [VALUE_WIDTH-1:0] c_i,
  input  logic signed [VALUE_WIDTH+3:0] tot_i,
  input  logic signed [VALUE_WIDTH+1:0] best_i,
  input  logic signed [VALUE_WIDTH-1:0] max_i,
  input  logic        [SIGMA_W-1:0]     sigma_i,
  input  logic        [RMS_W-1:0]       rms_i,
  output pcc_class_e                    class_o
);

  localparam int unsigned SW = VALUE_WIDTH + 4 + RMS_FRAC_BITS;
  localparam int unsigned CW = ((SW > THR_W + 2) ? SW : THR_W + 2) + 1;

  logic        [THR_W-1:0] thr;
  logic signed [CW-1:0]    thr1, thr2, thr3;
  logic signed [CW-1:0]    c_s, tot_s, best_s, max_s;
  logic                    neg, photon;

  assign thr  = THR_W'(sigma_i) * THR_W'(rms_i);
  assign thr1 = signed'(CW'(thr));
  assign thr2 = thr1 <<< 1;
  assign thr3 = thr1 + thr2;

  // pixel values lined up with the RMS fraction
  assign c_s    = CW'(c_i)    <<< RMS_FRAC_BITS;
  assign tot_s  = CW'(tot_i)  <<< RMS_FRAC_BITS;
  assign best_s = CW'(best_i) <<< RMS_FRAC_BITS;
  assign max_s  = CW'(max_i)  <<< RMS_FRAC_BITS;

  assign neg    = c_s < -thr1;
  assign photon = (max_s > thr1) || (tot_s > thr3) || (best_s > thr2);

  always_comb begin
    if (neg) begin
      class_o = CLASS_NEG;
    end else if (!photon) begin
      class_o = CLASS_PEDESTAL;
    end else if (c_i == max_i) begin
      class_o = CLASS_PEAK;
    end else begin
      class_o = CLASS_PHOTON;
    end
  end

endmodule

// ===== rtl/photon_cluster_classifier.sv =====
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   pix_nw_i .. pix_se_i, noise_rms_i
// output    out_valid_o / out_stall_i pixel_class_o
// config    APB (psel .. pready)      sigma_multiple at address 0
//
// One window per cycle sustained while out_stall_i stays low.
// Stage 1 registers the window, one combinational pass (sum/max trees, threshold
// multiply, compares) feeds the result register.
// Reset clears both valid flags and sets sigma_multiple to 3.
// A stalled result holds; stage 1 keeps taking a window while the result slot
// frees up in the same cycle, so in_stall_o rises only with both stages full.
`include "photon_cluster_classifier_defines.svh"

module photon_cluster_classifier import pcc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH   = 17,
  parameter int unsigned RMS_FRAC_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // window in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] pix_nw_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_n_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_ne_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_w_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_c_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_e_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_sw_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_s_i,
  input  logic signed [VALUE_WIDTH-1:0] pix_se_i,
  input  logic        [RMS_W-1:0]       noise_rms_i,
  // class out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [1:0]             pixel_class_o,
  // APB
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic        [PADDR_W-1:0]     paddr,
  input  logic        [PDATA_W-1:0]     pwdata,
  output logic        [PDATA_W-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned W = VALUE_WIDTH;

  // ---- configuration register ----
  logic [SIGMA_W-1:0] sigma_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIGMA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_RESET;
    end else if (cfg_wr) begin
      sigma_q <= pwdata[SIGMA_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SIGMA) ? PDATA_W'(sigma_q) : '0;

  // ---- flow control ----
  // out_ready: result slot empty or being drained this cycle.
  logic v1_q, out_valid_q;
  logic out_ready, in_ready;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !v1_q || out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        v1_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= v1_q;
      end
    end
  end

  // ---- stage 1: window register ----
  logic signed [W-1:0] win_q [9];
  logic        [RMS_W-1:0] rms_q;

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      win_q[0] <= pix_nw_i;
      win_q[1] <= pix_n_i;
      win_q[2] <= pix_ne_i;
      win_q[3] <= pix_w_i;
      win_q[4] <= pix_c_i;
      win_q[5] <= pix_e_i;
      win_q[6] <= pix_sw_i;
      win_q[7] <= pix_s_i;
      win_q[8] <= pix_se_i;
      rms_q    <= noise_rms_i;
    end
  end

  // ---- window features and classification ----
  logic signed [W+3:0] tot;
  logic signed [W+1:0] best;
  logic signed [W-1:0] mx;
  pcc_class_e          class_d;
  pcc_class_e          class_q;

  pcc_window #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_window (
    .pix_i  (win_q),
    .tot_o  (tot),
    .best_o (best),
    .max_o  (mx)
  );

  pcc_classify #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .RMS_FRAC_BITS (RMS_FRAC_BITS)
  ) u_classify (
    .c_i     (win_q[4]),
    .tot_i   (tot),
    .best_i  (best),
    .max_i   (mx),
    .sigma_i (sigma_q),
    .rms_i   (rms_q),
    .class_o (class_d)
  );

  // ---- result register ----
  always_ff @(posedge clk_i) begin
    if (out_ready && v1_q) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_class_o = class_q;

  // ---- checks ----
  `PCC_ASSERT(a_stall_needs_full, !in_stall_o || (v1_q && out_valid_q && out_stall_i), "input stalled with room in the pipe")
  `PCC_ASSERT_NEXT(a_stage1_moves, v1_q && out_ready, out_valid_q, "stage 1 window lost on the way to the result register")
  `PCC_ASSERT_NEXT(a_no_phantom, !v1_q && !out_stall_i, !out_valid_q, "result appeared without a window in stage 1")
  `PCC_ASSERT_NEXT(a_cfg_write, cfg_wr, sigma_q == $past(pwdata[SIGMA_W-1:0]), "sigma write not applied")

endmodule

// ===== bench/tb_photon_cluster_classifier.sv =====
`timescale 1ns / 100ps

module tb_photon_cluster_classifier import pcc_pkg::*; ();

  // Block geometry, matched to the DUT parameters below.
  localparam int VW   = 17;
  localparam int FRAC = 4;
  localparam longint SCALE = longint'(1) << FRAC;

  // Pixel extremes: full-scale positive and negative, and the bare sign bit
  // (one step past the stated range, still a legal bit pattern).
  localparam int PIX_MAX  = 65535;
  localparam int PIX_MIN  = -65535;
  localparam int PIX_WRAP = -65536;
  localparam int unsigned RMS_MAX = 20'hFFFFF;

  // Register map: index from paddr[2], byte address 4*index.
  localparam logic [PADDR_W-1:0] SIGMA_ADDR    = {REG_SIGMA, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {~REG_SIGMA, 2'b00};

  localparam int PHASES          = 6;
  localparam int WINDOWS_PER_PHASE = 305;
  localparam int LONG_HOLD       = 60;
  localparam int N_PROBES        = 21;

  // px[0..8] = nw, n, ne, w, c, e, sw, s, se
  typedef struct packed {
    logic [8:0][VW-1:0] px;
    logic [RMS_W-1:0]   rms;
  } window_t;

  // One row of the directed table; has_cls marks a class typed in by hand.
  typedef struct {
    window_t    w;
    bit         has_cls;
    pcc_class_e cls;
  } probe_t;

  bit                   clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [VW-1:0] pix_nw_i, pix_n_i, pix_ne_i;
  logic signed [VW-1:0] pix_w_i, pix_c_i, pix_e_i;
  logic signed [VW-1:0] pix_sw_i, pix_s_i, pix_se_i;
  logic [RMS_W-1:0]     noise_rms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           pixel_class_o;
  logic                 psel, penable, pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Shadow of the sigma register, classes still owed by the block.
  logic [SIGMA_W-1:0] sigma_q;
  pcc_class_e         class_q[$];
  int                 errors;
  int                 results_seen;

  // Idle controls, in percent per cycle; hold_req asks for one long stall.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int          hold_left;

  photon_cluster_classifier #(
    .VALUE_WIDTH  (VW),
    .RMS_FRAC_BITS(FRAC)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pix_nw_i     (pix_nw_i),
    .pix_n_i      (pix_n_i),
    .pix_ne_i     (pix_ne_i),
    .pix_w_i      (pix_w_i),
    .pix_c_i      (pix_c_i),
    .pix_e_i      (pix_e_i),
    .pix_sw_i     (pix_sw_i),
    .pix_s_i      (pix_s_i),
    .pix_se_i     (pix_se_i),
    .noise_rms_i  (noise_rms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_class_o(pixel_class_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    errors++;
  endtask

  // Append one class to the list of classes the block still owes.
  task automatic owe_class(input pcc_class_e c);
    class_q.insert(class_q.size(), c);
  endtask

  // Class of one window: threshold T = sigma * rms (fixed point), pixel
  // values scaled up by 2^FRAC so every compare is an exact integer compare.
  function automatic pcc_class_e classify_pixel(input window_t w,
                                                input logic [SIGMA_W-1:0] sig);
    longint v[9];
    longint tot, mx, best, thr;
    longint quad[4];
    bit     photon;
    int     i;
    tot = 0;
    mx  = 0;  // max starts at zero, never goes negative
    for (i = 0; i < 9; i++) begin
      v[i] = longint'($signed(w.px[i]));
      tot += v[i];
      if (v[i] > mx) mx = v[i];
    end
    // the four 2x2 quadrants that hold the center
    quad[0] = v[0] + v[1] + v[3] + v[4];
    quad[1] = v[1] + v[2] + v[4] + v[5];
    quad[2] = v[3] + v[4] + v[6] + v[7];
    quad[3] = v[4] + v[5] + v[7] + v[8];
    best = quad[0];
    for (i = 1; i < 4; i++)
      if (quad[i] > best) best = quad[i];
    thr = longint'(sig) * longint'(w.rms);

    if (v[4] * SCALE < -thr) return CLASS_NEG;
    photon = (mx * SCALE > thr) || (tot * SCALE > 3 * thr) || (best * SCALE > 2 * thr);
    if (!photon) return CLASS_PEDESTAL;
    return (v[4] == mx) ? CLASS_PEAK : CLASS_PHOTON;
  endfunction

  function automatic window_t mk_window(input int nw, input int n, input int ne,
                                        input int w, input int c, input int e,
                                        input int sw, input int s, input int se,
                                        input int unsigned rms);
    window_t win;
    int      vals[9];
    int      i;
    vals = '{nw, n, ne, w, c, e, sw, s, se};
    for (i = 0; i < 9; i++) win.px[i] = vals[i][VW-1:0];
    win.rms = rms[RMS_W-1:0];
    return win;
  endfunction

  function automatic window_t mk_flat(input int v, input int unsigned rms);
    return mk_window(v, v, v, v, v, v, v, v, v, rms);
  endfunction

  // Random window. Most windows are noise scaled to the current threshold,
  // often with one spike, so all four classes show up; the rest are raw
  // bit patterns or full-scale extremes.
  function automatic window_t rand_window(input logic [SIGMA_W-1:0] sig);
    window_t     w;
    int unsigned kind, unit, spot;
    longint      span;
    int          val;
    int          i;
    kind  = $urandom_range(0, 9);
    w.rms = ($urandom_range(0, 7) == 0) ? RMS_W'($urandom())
                                        : RMS_W'($urandom_range(0, 2047));
    span = ((longint'(sig) * longint'(w.rms)) >> FRAC) + 1;
    unit = (span > 30000) ? 30000 : int'(span);
    for (i = 0; i < 9; i++) begin
      case (kind)
        0, 1: w.px[i] = VW'($urandom());
        9: begin
          case ($urandom_range(0, 3))
            0: val = PIX_MAX;
            1: val = PIX_MIN;
            2: val = PIX_WRAP;
            default: val = 0;
          endcase
          w.px[i] = val[VW-1:0];
        end
        default: begin
          val = int'($urandom_range(0, 2 * unit)) - int'(unit);
          w.px[i] = val[VW-1:0];
        end
      endcase
    end
    if (kind inside {[2:8]} && $urandom_range(0, 3) == 0) begin
      spot = $urandom_range(0, 8);
      val  = int'($urandom_range(unit, 4 * unit));
      w.px[spot] = val[VW-1:0];
    end
    return w;
  endfunction

  // Offer one window, starting at a falling edge; returns at the falling
  // edge after the transfer with valid still high, so back-to-back windows
  // never lower and raise valid in the same step.
  task automatic send_window(input window_t w, input pcc_class_e want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pix_nw_i    <= w.px[0];
    pix_n_i     <= w.px[1];
    pix_ne_i    <= w.px[2];
    pix_w_i     <= w.px[3];
    pix_c_i     <= w.px[4];
    pix_e_i     <= w.px[5];
    pix_sw_i    <= w.px[6];
    pix_s_i     <= w.px[7];
    pix_se_i    <= w.px[8];
    noise_rms_i <= w.rms;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    owe_class(want);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed class has come out, so the block
  // is empty for a register access.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (class_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_sigma_readback();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, SIGMA_ADDR, '0, rd);
    if (rd !== PDATA_W'(sigma_q))
      flag_error($sformatf("sigma readback %0h, want %0h", rd, sigma_q));
  endtask

  // Write through the port; random upper bits must be dropped by the block.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [SIGMA_W-1:0] val);
    logic [PDATA_W-1:0] data, rd;
    data = {$urandom()};
    data[SIGMA_W-1:0] = val;
    apb_access(1'b1, addr, data, rd);
    if (addr == SIGMA_ADDR) sigma_q = val;  // unmapped index: ignored
    check_sigma_readback();
  endtask

  // Result side: stall pattern, with an occasional long hold-off counted here.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Every result transfer is checked against the oldest owed class.
  always @(posedge clk_i) begin : result_check
    pcc_class_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (class_q.size() == 0) begin
        flag_error($sformatf("result %0d: class %0d with none owed",
                             results_seen, pixel_class_o));
      end else begin
        want = class_q.pop_front();
        if (pixel_class_o !== want)
          flag_error($sformatf("result %0d: class %0d, want %0d (%s)",
                               results_seen, pixel_class_o, want, want.name()));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    probe_t       probes[N_PROBES];
    window_t      w;
    logic [SIGMA_W-1:0] sig_plan[PHASES];
    int           ph, n;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    {pix_nw_i, pix_n_i, pix_ne_i} = '0;
    {pix_w_i, pix_c_i, pix_e_i}   = '0;
    {pix_sw_i, pix_s_i, pix_se_i} = '0;
    noise_rms_i    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sigma_q        = SIGMA_RESET;
    errors         = 0;
    results_seen   = 0;
    send_idle_pct  = 25;
    recv_stall_pct = 77;
    hold_req       = 1'b0;
    hold_left      = 0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_sigma_readback();  // reset value

    // Directed windows at the reset sigma of 3. With rms 0 the threshold is
    // zero, so the class is plain to see; the rest go through the predictor.
    probes = '{
      '{mk_flat(0, 0), 1'b1, CLASS_PEDESTAL},
      '{mk_flat(PIX_MAX, 0), 1'b1, CLASS_PEAK},
      '{mk_flat(PIX_MIN, 0), 1'b1, CLASS_NEG},
      '{mk_flat(PIX_WRAP, 0), 1'b1, CLASS_NEG},
      '{mk_flat(PIX_WRAP, RMS_MAX), 1'b0, CLASS_PEDESTAL},
      '{mk_flat(PIX_MAX, RMS_MAX), 1'b0, CLASS_PEDESTAL},
      '{mk_window(0, 0, 0, 0, PIX_MAX, 0, 0, 0, 0, 0), 1'b1, CLASS_PEAK},
      '{mk_window(0, 0, 0, 0, PIX_MAX, 0, 0, 0, 0, RMS_MAX), 1'b0, CLASS_PEDESTAL},
      '{mk_window(0, 2, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, CLASS_PHOTON},
      '{mk_window(0, 0, 0, 0, -1, 0, 0, 0, 0, 0), 1'b1, CLASS_NEG},
      // center right at -T, then one step below it
      '{mk_window(0, 0, 0, 0, -3, 0, 0, 0, 0, 16), 1'b0, CLASS_PEDESTAL},
      '{mk_window(0, 0, 0, 0, -4, 0, 0, 0, 0, 16), 1'b0, CLASS_PEDESTAL},
      // max exactly at T, then one above
      '{mk_window(0, 0, 0, 0, 3, 0, 0, 0, 0, 16), 1'b0, CLASS_PEDESTAL},
      '{mk_window(0, 0, 0, 0, 4, 0, 0, 0, 0, 16), 1'b0, CLASS_PEDESTAL},
      // photon by window total alone, then by best quadrant alone
      '{mk_window(2, 2, 2, 2, -2, 2, 2, 2, 2, 16), 1'b0, CLASS_PEDESTAL},
      '{mk_window(2, 2, 0, 2, 2, 0, 0, 0, 0, 16), 1'b0, CLASS_PEDESTAL},
      // center ties a neighbor for the max
      '{mk_window(0, 0, 0, 0, 5, 5, 0, 0, 0, 16), 1'b0, CLASS_PEDESTAL},
      // smallest nonzero rms (one fraction LSB)
      '{mk_window(0, 0, 0, 0, 1, 0, 0, 0, 0, 1), 1'b0, CLASS_PEDESTAL},
      // alternating bit patterns on every field
      '{mk_flat(32'h0AAAA, 20'hAAAAA), 1'b0, CLASS_PEDESTAL},
      '{mk_flat(32'h15555, 20'h55555), 1'b0, CLASS_PEDESTAL},
      '{mk_window(32'h0AAAA, 32'h15555, 32'h0AAAA, 32'h15555, 32'h0AAAA,
                  32'h15555, 32'h0AAAA, 32'h15555, 32'h0AAAA, 20'h5A5A5),
        1'b0, CLASS_PEDESTAL}
    };

    foreach (probes[i])
      send_window(probes[i].w, probes[i].has_cls ? probes[i].cls
                                                 : classify_pixel(probes[i].w, sigma_q));
    settle();

    // Random phases: zero and full-scale sigma among the settings; idle mix
    // changes every two phases, the last two run without idling.
    sig_plan = '{4'd0, 4'd15, 4'd1, SIGMA_W'($urandom_range(2, 14)), 4'd8,
                 SIGMA_W'($urandom_range(1, 14))};
    for (ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = (ph < 2) ? 25 : (ph < 4) ? 77 : 0;
      recv_stall_pct = (ph < 2) ? 77 : (ph < 4) ? 25 : 0;
      if (ph == 3) write_reg(UNMAPPED_ADDR, SIGMA_W'($urandom()));
      write_reg(SIGMA_ADDR, sig_plan[ph]);
      for (n = 0; n < WINDOWS_PER_PHASE; n++) begin
        // long output hold-off: both stages fill and the input stalls
        if (ph == 4 && n == 40) hold_req = 1'b1;
        // sender pauses mid-phase until the pipe is empty
        if (ph == 1 && n == 150) settle();
        w = rand_window(sigma_q);
        send_window(w, classify_pixel(w, sigma_q));
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_window.sv
rtl/pcc_classify.sv
rtl/photon_cluster_classifier.sv
bench/tb_photon_cluster_classifier.sv
